/* src/gs1d_pkg.sv */
package gs1d_pkg;

    localparam int STRIP_LENGTH_DEF = 256;

    localparam logic [15:0] ONE_Q15 = 16'h8000;

    typedef enum logic [1:0] {
        CMD_STEP   = 2'd0,
        CMD_READ   = 2'd1,
        CMD_RESEED = 2'd2
    } t_cmd_code;

    typedef enum logic [2:0] {
        S_SEED,
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic latch;       // capture the input word
        logic seed_we;     // write initial pattern at addr
        logic sweep_rd;    // read one cell of the sweep at addr
        logic sweep_first; // first read of a sweep
        logic inject_on;   // add injection to V on the read path
        logic out_rd;      // read the selected cell
        logic out_load;    // load output registers from read data
    } t_dp_cmd;

endpackage

/* src/gray_scott_1d_stencil_top.sv */
// channel  dir  handshake           payload
// input    in   i_valid / o_ready   i_command i_inject_amount i_iterations i_feed_rate
//                                   i_kill_rate i_time_step i_cell_index
// result   out  o_valid / i_ready   o_u_value o_v_value
//
// One word at a time. A reseed rewrites every cell of the strip before its reply.
// Step: per iteration STRIP_LENGTH+1 memory reads through the single read port of
// the field memories, then the pipeline drains.
// After reset the fields are seeded in a pass over all STRIP_LENGTH cells, o_ready low.
// The result holds in its register until taken; o_ready returns after that.
module gray_scott_1d_stencil_top #(
    parameter int STRIP_LENGTH = gs1d_pkg::STRIP_LENGTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_inject_amount,
    input  logic [1:0]  i_iterations,
    input  logic [15:0] i_feed_rate,
    input  logic [15:0] i_kill_rate,
    input  logic [9:0]  i_time_step,
    input  logic [7:0]  i_cell_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_u_value,
    output logic [15:0] o_v_value
);

    localparam int AW = $clog2(STRIP_LENGTH);

    gs1d_pkg::t_dp_cmd dp_cmd;
    logic [AW-1:0]     addr;
    logic              pipe_busy;

    gs1d_ctrl #(
        .STRIP_LENGTH(STRIP_LENGTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_iterations (i_iterations),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .i_pipe_busy  (pipe_busy),
        .o_cmd        (dp_cmd),
        .o_addr       (addr)
    );

    gs1d_datapath #(
        .STRIP_LENGTH(STRIP_LENGTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_addr          (addr),
        .i_inject_amount (i_inject_amount),
        .i_feed_rate     (i_feed_rate),
        .i_kill_rate     (i_kill_rate),
        .i_time_step     (i_time_step),
        .i_cell_index    (i_cell_index),
        .o_pipe_busy     (pipe_busy),
        .o_u_value       (o_u_value),
        .o_v_value       (o_v_value)
    );

endmodule

/* src/gs1d_ctrl.sv */
module gs1d_ctrl #(
    parameter int STRIP_LENGTH = gs1d_pkg::STRIP_LENGTH_DEF,
    localparam int AW = $clog2(STRIP_LENGTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_command,
    input  logic [1:0]          i_iterations,
    output logic                o_valid,
    input  logic                i_ready,
    input  logic                i_pipe_busy,
    output gs1d_pkg::t_dp_cmd   o_cmd,
    output logic [AW-1:0]       o_addr
);

    gs1d_pkg::t_state r_state, n_state;
    logic [AW:0]      r_cnt, n_cnt;
    logic             r_second, n_second;
    logic             r_two, n_two;
    logic             r_reply, n_reply;

    logic accept;
    logic cnt_at_len;
    logic cnt_at_last;

    assign accept      = i_valid && (r_state == gs1d_pkg::S_IDLE);
    assign cnt_at_len  = (r_cnt == (AW+1)'(STRIP_LENGTH));
    assign cnt_at_last = (r_cnt == (AW+1)'(STRIP_LENGTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gs1d_pkg::S_SEED;
            r_cnt    <= '0;
            r_second <= 1'b0;
            r_two    <= 1'b0;
            r_reply  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_second <= n_second;
            r_two    <= n_two;
            r_reply  <= n_reply;
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_second = r_second;
        n_two    = r_two;
        n_reply  = r_reply;
        case (r_state)
            gs1d_pkg::S_SEED: begin
                n_cnt = r_cnt + 1'b1;
                if (cnt_at_last) begin
                    n_cnt   = '0;
                    n_state = r_reply ? gs1d_pkg::S_OUT_RD : gs1d_pkg::S_IDLE;
                end
            end
            gs1d_pkg::S_IDLE: begin
                if (accept) begin
                    n_cnt = '0;
                    case (i_command)
                        gs1d_pkg::CMD_STEP: begin
                            n_state  = gs1d_pkg::S_SWEEP;
                            n_second = 1'b0;
                            n_two    = i_iterations[1];
                        end
                        gs1d_pkg::CMD_RESEED: begin
                            n_state = gs1d_pkg::S_SEED;
                            n_reply = 1'b1;
                        end
                        default: n_state = gs1d_pkg::S_OUT_RD;
                    endcase
                end
            end
            gs1d_pkg::S_SWEEP: begin
                n_cnt = r_cnt + 1'b1;
                if (cnt_at_len) begin
                    n_state = gs1d_pkg::S_DRAIN;
                end
            end
            gs1d_pkg::S_DRAIN: begin
                if (!i_pipe_busy) begin
                    n_cnt = '0;
                    if (r_two && !r_second) begin
                        n_second = 1'b1;
                        n_state  = gs1d_pkg::S_SWEEP;
                    end else begin
                        n_state = gs1d_pkg::S_OUT_RD;
                    end
                end
            end
            gs1d_pkg::S_OUT_RD: n_state = gs1d_pkg::S_OUT_LD;
            gs1d_pkg::S_OUT_LD: n_state = gs1d_pkg::S_OUT_WAIT;
            gs1d_pkg::S_OUT_WAIT: begin
                if (i_ready) begin
                    n_state = gs1d_pkg::S_IDLE;
                end
            end
            default: n_state = gs1d_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        o_addr  = cnt_at_len ? AW'(STRIP_LENGTH - 1) : r_cnt[AW-1:0];
        case (r_state)
            gs1d_pkg::S_SEED: o_cmd.seed_we = 1'b1;
            gs1d_pkg::S_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.latch = accept;
            end
            gs1d_pkg::S_SWEEP: begin
                o_cmd.sweep_rd    = 1'b1;
                o_cmd.sweep_first = (r_cnt == '0);
                o_cmd.inject_on   = !r_second;
            end
            gs1d_pkg::S_OUT_RD:   o_cmd.out_rd   = 1'b1;
            gs1d_pkg::S_OUT_LD:   o_cmd.out_load = 1'b1;
            gs1d_pkg::S_OUT_WAIT: o_valid        = 1'b1;
            default: ;
        endcase
    end

endmodule

/* src/gs1d_datapath.sv */
module gs1d_datapath #(
    parameter int STRIP_LENGTH = gs1d_pkg::STRIP_LENGTH_DEF,
    localparam int AW = $clog2(STRIP_LENGTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gs1d_pkg::t_dp_cmd   i_cmd,
    input  logic [AW-1:0]       i_addr,
    input  logic [15:0]         i_inject_amount,
    input  logic [15:0]         i_feed_rate,
    input  logic [15:0]         i_kill_rate,
    input  logic [9:0]          i_time_step,
    input  logic [7:0]          i_cell_index,
    output logic                o_pipe_busy,
    output logic [15:0]         o_u_value,
    output logic [15:0]         o_v_value
);

    localparam int unsigned MID = STRIP_LENGTH / 2;

    // latched input word
    logic [15:0] r_inj, r_f, r_k;
    logic [9:0]  r_dt;
    logic [7:0]  r_cell;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_inj  <= i_inject_amount;
            r_f    <= i_feed_rate;
            r_k    <= i_kill_rate;
            r_dt   <= i_time_step;
            r_cell <= i_cell_index;
        end
    end

    logic [31:0]   cell_ext;
    logic          cell_in_range;
    logic [AW-1:0] out_addr;

    assign cell_ext      = 32'(r_cell);
    assign cell_in_range = (cell_ext < 32'(STRIP_LENGTH));
    assign out_addr      = cell_ext[AW-1:0];

    // field memories
    logic [15:0]   mem_u [STRIP_LENGTH];
    logic [15:0]   mem_v [STRIP_LENGTH];
    logic [15:0]   r_rd_u, r_rd_v;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [15:0]   wr_u, wr_v;
    logic          wr_en;

    assign rd_addr = i_cmd.out_rd ? out_addr : i_addr;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_u[wr_addr] <= wr_u;
            mem_v[wr_addr] <= wr_v;
        end
        r_rd_u <= mem_u[rd_addr];
        r_rd_v <= mem_v[rd_addr];
    end

    // read arrival
    logic          r_arr_vld, r_arr_first, r_arr_inj;
    logic [AW-1:0] r_arr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arr_vld <= 1'b0;
        end else begin
            r_arr_vld <= i_cmd.sweep_rd;
        end
        r_arr_first <= i_cmd.sweep_first;
        r_arr_inj   <= i_cmd.inject_on;
        r_arr_addr  <= i_addr;
    end

    logic [31:0] arr_a32;
    logic        inj_hit;
    logic [16:0] inj_sum;
    logic [15:0] x_v;

    assign arr_a32 = 32'(r_arr_addr);
    assign inj_hit = r_arr_inj && (arr_a32 >= MID - 5) && (arr_a32 <= MID + 5);
    assign inj_sum = {1'b0, r_rd_v} + {1'b0, r_inj};
    assign x_v     = !inj_hit ? r_rd_v :
                     (inj_sum > {1'b0, gs1d_pkg::ONE_Q15}) ? gs1d_pkg::ONE_Q15 : inj_sum[15:0];

    // stage 1: three-cell window, edge cells replicate
    logic [15:0]   r_ul, r_uc, r_ur, r_vl, r_vc, r_vr;
    logic          r_one;
    logic [AW-1:0] r_idx;
    logic          r_s1_vld;
    logic [AW-1:0] r_s1_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= r_arr_vld && !r_arr_first;
        end
        if (r_arr_vld) begin
            r_ur     <= r_rd_u;
            r_uc     <= r_ur;
            r_ul     <= r_one ? r_ur : r_uc;
            r_vr     <= x_v;
            r_vc     <= r_vr;
            r_vl     <= r_one ? r_vr : r_vc;
            r_one    <= r_arr_first;
            r_s1_idx <= r_idx;
            r_idx    <= r_arr_first ? '0 : r_idx + 1'b1;
        end
    end

    // stage 2: laplacians and first products
    logic signed [17:0] lap_u, lap_v;
    logic [31:0]        p_uv, p_feed;
    logic [32:0]        p_loss;
    logic [16:0]        kf;
    logic [15:0]        one_minus_u;

    assign lap_u = $signed({2'b00, r_ul}) + $signed({2'b00, r_ur}) - $signed({1'b0, r_uc, 1'b0});
    assign lap_v = $signed({2'b00, r_vl}) + $signed({2'b00, r_vr}) - $signed({1'b0, r_vc, 1'b0});
    assign one_minus_u = gs1d_pkg::ONE_Q15 - r_uc;
    assign kf          = {1'b0, r_k} + {1'b0, r_f};
    assign p_uv        = r_uc * r_vc;
    assign p_feed      = r_f * one_minus_u;
    assign p_loss      = kf * r_vc;

    logic signed [17:0] r_s2_lap_u, r_s2_lap_v;
    logic [15:0]        r_s2_uv, r_s2_feed, r_s2_u, r_s2_v;
    logic [16:0]        r_s2_loss;
    logic               r_s2_vld;
    logic [AW-1:0]      r_s2_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_lap_u <= lap_u;
        r_s2_lap_v <= lap_v;
        r_s2_uv    <= p_uv[30:15];
        r_s2_feed  <= p_feed[31:16];
        r_s2_loss  <= p_loss[32:16];
        r_s2_u     <= r_uc;
        r_s2_v     <= r_vc;
        r_s2_idx   <= r_s1_idx;
    end

    // stage 3: uvv
    logic [31:0] p_uvv;
    assign p_uvv = r_s2_uv * r_s2_v;

    logic signed [17:0] r_s3_lap_u, r_s3_lap_v;
    logic [15:0]        r_s3_uvv, r_s3_feed, r_s3_u, r_s3_v;
    logic [16:0]        r_s3_loss;
    logic               r_s3_vld;
    logic [AW-1:0]      r_s3_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
        r_s3_lap_u <= r_s2_lap_u;
        r_s3_lap_v <= r_s2_lap_v;
        r_s3_uvv   <= p_uvv[30:15];
        r_s3_feed  <= r_s2_feed;
        r_s3_loss  <= r_s2_loss;
        r_s3_u     <= r_s2_u;
        r_s3_v     <= r_s2_v;
        r_s3_idx   <= r_s2_idx;
    end

    // stage 4: rates of change
    logic signed [18:0] du, dv, lap_v_half;

    assign lap_v_half = $signed({r_s3_lap_v[17], r_s3_lap_v}) >>> 1;
    assign du = $signed({r_s3_lap_u[17], r_s3_lap_u}) - $signed({3'b000, r_s3_uvv})
              + $signed({3'b000, r_s3_feed});
    assign dv = lap_v_half + $signed({3'b000, r_s3_uvv}) - $signed({2'b00, r_s3_loss});

    logic signed [18:0] r_s4_du, r_s4_dv;
    logic [15:0]        r_s4_u, r_s4_v;
    logic               r_s4_vld;
    logic [AW-1:0]      r_s4_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
        r_s4_du  <= du;
        r_s4_dv  <= dv;
        r_s4_u   <= r_s3_u;
        r_s4_v   <= r_s3_v;
        r_s4_idx <= r_s3_idx;
    end

    // write stage: scale by dt, integrate, clamp
    logic signed [29:0] pu, pv, nu, nv;
    logic signed [10:0] dt_s;
    logic [15:0]        cu, cv;

    assign dt_s = $signed({1'b0, r_dt});
    assign pu   = r_s4_du * dt_s;
    assign pv   = r_s4_dv * dt_s;
    assign nu   = $signed({14'd0, r_s4_u}) + (pu >>> 8);
    assign nv   = $signed({14'd0, r_s4_v}) + (pv >>> 8);

    always_comb begin
        if (nu < 0) begin
            cu = '0;
        end else if (nu > $signed({14'd0, gs1d_pkg::ONE_Q15})) begin
            cu = gs1d_pkg::ONE_Q15;
        end else begin
            cu = nu[15:0];
        end
        if (nv < 0) begin
            cv = '0;
        end else if (nv > $signed({14'd0, gs1d_pkg::ONE_Q15})) begin
            cv = gs1d_pkg::ONE_Q15;
        end else begin
            cv = nv[15:0];
        end
    end

    // initial pattern
    logic [31:0] seed_a32;
    logic        seed_hit;

    assign seed_a32 = 32'(i_addr);
    assign seed_hit = (seed_a32 >= MID - 6) && (seed_a32 <= MID + 6);

    always_comb begin
        wr_en   = i_cmd.seed_we || r_s4_vld;
        wr_addr = i_cmd.seed_we ? i_addr : r_s4_idx;
        if (i_cmd.seed_we) begin
            wr_u = seed_hit ? 16'd0 : gs1d_pkg::ONE_Q15;
            wr_v = seed_hit ? gs1d_pkg::ONE_Q15 : 16'd0;
        end else begin
            wr_u = cu;
            wr_v = cv;
        end
    end

    assign o_pipe_busy = r_arr_vld || r_s1_vld || r_s2_vld || r_s3_vld || r_s4_vld;

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_u_value <= cell_in_range ? r_rd_u : 16'd0;
            o_v_value <= cell_in_range ? r_rd_v : 16'd0;
        end
    end

endmodule
